FILE: src/vag_pkg.sv
package vag_pkg;

  // Field widths
  localparam int SMP_W   = 16;               // PCM sample, Q1.15
  localparam int MAG_W   = SMP_W;            // |sample| reaches 2^15
  localparam int THR_W   = 17;               // threshold, Q0.16 with 1.0 allowed
  localparam int HANG_W  = 8;
  localparam int CFG_W   = THR_W;            // widest register

  // Frame accumulation
  localparam int MAX_FRAME = 4096;
  localparam int CNT_W     = $clog2(MAX_FRAME + 1);
  localparam int SQ_W      = 2 * MAG_W - 1;  // largest square is 2^30
  localparam int SUM_W     = SQ_W + CNT_W - 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);

  // Shared shift-add multiplier: multiplicand up to thr*count, multiplier up to thr
  localparam int MUL_A_W   = THR_W + CNT_W;
  localparam int MUL_B_W   = THR_W;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);
  localparam logic [MUL_CNT_W-1:0] MUL_STEPS = MUL_CNT_W'(MUL_B_W);

  // Energy compare: 4*sum against thr^2*count
  localparam int LHS_W = SUM_W + 2;

  localparam logic [THR_W-1:0] THR_MAX = THR_W'(65536);

  // Stream payload widths
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;

  // Register indexes
  typedef enum logic [1:0] {
    CFG_PTT_MODE  = 2'd0,
    CFG_VAD_MODE  = 2'd1,
    CFG_THRESHOLD = 2'd2,
    CFG_HANGOVER  = 2'd3
  } cfg_idx_t;

  // What the gate decision needs at the end of a frame
  typedef struct packed {
    logic ptt_mode;
    logic vad_mode;
    logic vad_flag;
    logic key;
    logic energy_pass;
  } decide_in_t;

endpackage

FILE: src/vag_sermul.sv
// Radix-2 shift-add multiplier, one multiplier bit per cycle.
module vag_sermul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [vag_pkg::MUL_A_W-1:0]   a,
  input  logic [vag_pkg::MUL_B_W-1:0]   b,
  output logic                          done,
  output logic [vag_pkg::MUL_P_W-1:0]   p
);

  logic [vag_pkg::MUL_A_W-1:0]   a_r, a_nxt;
  logic [vag_pkg::MUL_P_W-1:0]   p_r, p_nxt;
  logic [vag_pkg::MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          done_r, done_nxt;
  logic [vag_pkg::MUL_A_W:0]     part;

  always_comb begin
    part     = {1'b0, p_r[vag_pkg::MUL_P_W-1:vag_pkg::MUL_B_W]}
             + (p_r[0] ? {1'b0, a_r} : '0);
    a_nxt    = a_r;
    p_nxt    = p_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt   = a;
      p_nxt   = {{vag_pkg::MUL_A_W{1'b0}}, b};
      cnt_nxt = vag_pkg::MUL_STEPS;
    end else if (cnt_r != '0) begin
      // add on the low bit, shift product and multiplier right together
      p_nxt    = {part, p_r[vag_pkg::MUL_B_W-1:1]};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == vag_pkg::MUL_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    p_r <= p_nxt;
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

FILE: src/vag_decide.sv
// Frame gate decision and hangover counter.
module vag_decide (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       commit,
  input  vag_pkg::decide_in_t        din,
  input  logic [vag_pkg::HANG_W-1:0] hang_reload,
  output logic                       tx
);

  logic [vag_pkg::HANG_W-1:0] hang_r, hang_nxt;
  logic                       hang_nz;

  always_comb begin
    hang_nz  = (hang_r != '0);
    hang_nxt = hang_r;
    tx       = 1'b0;
    if (din.ptt_mode) begin
      if (din.key) begin
        hang_nxt = hang_reload;
        tx       = 1'b1;
      end else if (hang_nz) begin
        // send only while the count stays above zero after the decrement
        hang_nxt = hang_r - 1'b1;
        tx       = (hang_r != vag_pkg::HANG_W'(1));
      end
    end else if (!din.vad_mode) begin
      tx = 1'b1;
    end else if (din.vad_flag && din.energy_pass) begin
      hang_nxt = hang_reload;
      tx       = 1'b1;
    end else if (hang_nz) begin
      hang_nxt = hang_r - 1'b1;
      tx       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hang_r <= '0;
    end else if (commit) begin
      hang_r <= hang_nxt;
    end
  end

endmodule

FILE: src/voice_activity_gate_ptt_hangover_unit.sv
// Channel  | Ports                                  | Payload
// ---------+----------------------------------------+-------------------------------------
// in       | in_tvalid in_tready in_tdata in_tlast  | tdata[15:0] sample, tlast frame_last,
//          | in_tuser                               | tuser[0] external_vad, [1] key_pressed
// out      | out_tvalid out_tready out_tdata        | tdata[0] transmit, [7:1] zero
// cfg      | cfg_wr_en cfg_index cfg_data           | index 0..3, data up to 17 bits
//
// A sample that is not last passes the transfer, the serial squarer (one step per
// multiplier bit, then the done flag) and the accumulate step. The last sample of a frame
// adds two more passes of the same multiplier (thr*count, then *thr) and then the
// decision step.
// Reset (rst_n low, synchronous) clears the accumulators, hangover and control.
// The output register holds one result. A stalled result does not stop the intake or the
// squaring of new samples, but the next decision waits for it, with the intake closed.
module voice_activity_gate_ptt_hangover_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [vag_pkg::IN_TDATA_W-1:0]  in_tdata,   // [15:0] sample
  input  logic                            in_tlast,   // frame_last
  input  logic [vag_pkg::IN_TUSER_W-1:0]  in_tuser,   // [0] external_vad, [1] key_pressed
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [vag_pkg::OUT_TDATA_W-1:0] out_tdata,  // [0] transmit, [7:1] zero
  // configuration writes
  input  logic                            cfg_wr_en,
  input  logic [1:0]                      cfg_index,
  input  logic [vag_pkg::CFG_W-1:0]       cfg_data
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,  // wait for a sample
    ST_SQ   = 6'b000010,  // square |sample|
    ST_ACC  = 6'b000100,  // add square into frame sum
    ST_TC   = 6'b001000,  // thr * count
    ST_TT   = 6'b010000,  // (thr * count) * thr
    ST_DEC  = 6'b100000   // compare, decide, load result
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic                        ptt_mode_r;
  logic                        vad_mode_r;
  logic [vag_pkg::THR_W-1:0]   thr_r;
  logic [vag_pkg::HANG_W-1:0]  hang_frames_r;
  logic [vag_pkg::THR_W-1:0]   thr_wr;

  // Per-sample context held across the multiplier passes
  logic last_r, vad_r, key_r;

  // Frame accumulators
  logic [vag_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic [vag_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;

  // Output register
  logic                            out_tvalid_r, out_tvalid_nxt;
  logic [vag_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // Multiplier hookup
  logic                          mul_start;
  logic [vag_pkg::MUL_A_W-1:0]   mul_a;
  logic [vag_pkg::MUL_B_W-1:0]   mul_b;
  logic                          mul_done;
  logic [vag_pkg::MUL_P_W-1:0]   mul_p;

  logic                          in_xfer;
  logic [vag_pkg::MAG_W-1:0]     mag;
  logic [vag_pkg::LHS_W-1:0]     lhs;
  logic                          commit;
  logic                          tx;
  vag_pkg::decide_in_t           dec_in;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  // Two's complement magnitude; -32768 maps to 32768, which fits unsigned
  assign mag = in_tdata[vag_pkg::SMP_W-1] ? (~in_tdata[vag_pkg::SMP_W-1:0] + 1'b1)
                                          : in_tdata[vag_pkg::SMP_W-1:0];

  // Threshold above 1.0 saturates at the write
  assign thr_wr = (cfg_data[vag_pkg::THR_W-1] && (cfg_data[vag_pkg::THR_W-2:0] != '0))
                ? vag_pkg::THR_MAX : cfg_data[vag_pkg::THR_W-1:0];

  // 4*sum against thr^2*count, both exact
  assign lhs = {sum_r, 2'b00};

  assign dec_in.ptt_mode    = ptt_mode_r;
  assign dec_in.vad_mode    = vad_mode_r;
  assign dec_in.vad_flag    = vad_r;
  assign dec_in.key         = key_r;
  assign dec_in.energy_pass = (vag_pkg::MUL_P_W'(lhs) >= mul_p);

  assign commit = (state_r == ST_DEC) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt      = state_r;
    sum_nxt        = sum_r;
    cnt_nxt        = cnt_r;
    mul_start      = 1'b0;
    mul_a          = '0;
    mul_b          = '0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          mul_start = 1'b1;
          mul_a     = vag_pkg::MUL_A_W'(mag);
          mul_b     = vag_pkg::MUL_B_W'(mag);
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        if (mul_done) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        // saturate: past the frame limit, sum and count both hold
        if (cnt_r < vag_pkg::CNT_MAX) begin
          sum_nxt = sum_r + vag_pkg::SUM_W'(mul_p[vag_pkg::SQ_W-1:0]);
          cnt_nxt = cnt_r + 1'b1;
        end
        if (last_r) begin
          mul_start = 1'b1;
          mul_a     = vag_pkg::MUL_A_W'(cnt_nxt);
          mul_b     = thr_r;
          state_nxt = ST_TC;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TC: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = mul_p[vag_pkg::MUL_A_W-1:0];
          mul_b     = thr_r;
          state_nxt = ST_TT;
        end
      end
      ST_TT: begin
        if (mul_done) begin
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        // hold here until the output register is free
        if (commit) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = vag_pkg::OUT_TDATA_W'(tx);
          sum_nxt        = '0;
          cnt_nxt        = '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      sum_r         <= '0;
      cnt_r         <= '0;
      out_tvalid_r  <= 1'b0;
      ptt_mode_r    <= 1'b0;
      vad_mode_r    <= 1'b1;
      thr_r         <= vag_pkg::THR_W'(1311);
      hang_frames_r <= vag_pkg::HANG_W'(10);
    end else begin
      state_r      <= state_nxt;
      sum_r        <= sum_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          vag_pkg::CFG_PTT_MODE:  ptt_mode_r    <= cfg_data[0];
          vag_pkg::CFG_VAD_MODE:  vad_mode_r    <= cfg_data[0];
          vag_pkg::CFG_THRESHOLD: thr_r         <= thr_wr;
          vag_pkg::CFG_HANGOVER:  hang_frames_r <= cfg_data[vag_pkg::HANG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers: capture the sample context on transfer
  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    if (in_xfer) begin
      last_r <= in_tlast;
      vad_r  <= in_tuser[0];
      key_r  <= in_tuser[1];
    end
  end

  vag_sermul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  vag_decide u_dec (
    .clk         (clk),
    .rst_n       (rst_n),
    .commit      (commit),
    .din         (dec_in),
    .hang_reload (hang_frames_r),
    .tx          (tx)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

FILE: src/vag_chk.sv
module vag_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [vag_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  // One sample at a time: intake closes right after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("intake open right after a transfer");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A sample that is not last brings no new result
  a_no_result_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tlast) |=> !$rose(out_tvalid))
    else $error("result after a sample that is not last");

  // Only the transmit bit is ever set
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[vag_pkg::OUT_TDATA_W-1:1] == '0))
    else $error("padding bits of result set");

endmodule

bind voice_activity_gate_ptt_hangover_unit vag_chk u_vag_chk (.*);
